// ===== hw/rtl/csv_pkg.sv =====
// ----------------------------------------------------------------------------
// csv_pkg
// Shared types and constants for the cigar string validator: character
// codes, operation classes and the classified word passed front to back.
// ----------------------------------------------------------------------------
package csv_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH         = 2;
  localparam int SEQ_BITS            = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_MATCH,
    OP_SKIP,
    OP_SOFT,
    OP_HARD,
    OP_OTHER
  } op_class_t;

  typedef struct packed {
    op_class_t             op;
    logic [3:0]            digit;
    logic                  is_last;
    logic                  lone_star;
    logic [SEQ_BITS-1:0]   seq_length;
  } csv_word_t;

endpackage

// ===== hw/rtl/csv_front.sv =====
// ----------------------------------------------------------------------------
// csv_front
// Accepts characters, classifies each one into an operation class and
// spots the lone star string.
// ----------------------------------------------------------------------------
module csv_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   cigar_char,
  input  logic                         is_last,
  input  logic [csv_pkg::SEQ_BITS-1:0] seq_length,
  input  logic                         q_ready,
  output logic                         push,
  output csv_pkg::csv_word_t           word
);
  import csv_pkg::*;

  logic      at_first_char;
  op_class_t op;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  always_comb begin
    if (cigar_char inside {[CH_ZERO:CH_NINE]}) begin
      op = OP_DIGIT;
    end else begin
      case (cigar_char)
        CH_M, CH_I, CH_EQ, CH_X: op = OP_MATCH;
        CH_D, CH_N, CH_P:        op = OP_SKIP;
        CH_S:                    op = OP_SOFT;
        CH_H:                    op = OP_HARD;
        default:                 op = OP_OTHER;
      endcase
    end
  end

  always_comb begin
    word.op         = op;
    word.digit      = cigar_char[3:0];
    word.is_last    = is_last;
    word.lone_star  = at_first_char && is_last && (cigar_char == CH_STAR);
    word.seq_length = seq_length;
  end

  // first character of a string follows reset or a last character
  always_ff @(posedge clk) begin
    if (rst) begin
      at_first_char <= 1'b1;
    end else if (push) begin
      at_first_char <= is_last;
    end
  end

endmodule

// ===== hw/rtl/csv_queue.sv =====
// ----------------------------------------------------------------------------
// csv_queue
// Short first-in first-out queue of classified words between the front
// and the back.
// ----------------------------------------------------------------------------
module csv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csv_pkg::csv_word_t wr_word,
  output logic               wr_ready,
  output logic               rd_valid,
  input  logic               rd_ready,
  output csv_pkg::csv_word_t rd_word
);
  import csv_pkg::*;

  localparam int PtrBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

  csv_word_t            mem [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CountBits-1:0] count;
  logic                 pop;

  assign wr_ready = (count != CountBits'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign pop      = rd_valid && rd_ready;
  assign rd_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/csv_back.sv =====
// ----------------------------------------------------------------------------
// csv_back
// Carries out classified words: decimal run accumulation, saturating sum
// of query-consuming runs, clip phase tracking and the final verdict.
// ----------------------------------------------------------------------------
module csv_back #(
  parameter int LengthBits = csv_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  csv_pkg::csv_word_t           q_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         cigar_valid,
  output logic                         length_matches,
  output logic                         order_legal,
  output logic [csv_pkg::SEQ_BITS-1:0] query_length_sum
);
  import csv_pkg::*;

  localparam int ProdBits = LengthBits + 4;
  localparam int WideBits = (LengthBits > SEQ_BITS) ? LengthBits : SEQ_BITS;

  typedef enum logic [2:0] {
    PH_LEAD_H,
    PH_LEAD_S,
    PH_BODY,
    PH_TRAIL_S,
    PH_TRAIL_H,
    PH_BAD
  } phase_t;

  phase_t                phase;
  phase_t                phase_next;
  logic [LengthBits-1:0] run_value;
  logic [LengthBits-1:0] run_value_next;
  logic [LengthBits-1:0] consumed_sum;
  logic [LengthBits-1:0] consumed_sum_next;
  logic                  saturated_flag;
  logic                  saturated_flag_next;

  logic [ProdBits-1:0]   run_ext;
  logic [ProdBits-1:0]   prod;
  logic [LengthBits:0]   sum_add;
  logic                  is_body;
  logic [WideBits-1:0]   sum_wide;
  logic [WideBits-1:0]   seq_wide;
  logic                  match;
  logic                  order;
  logic                  pop;

  assign q_ready = !q_word.is_last || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // run * 10 + digit, overflow shows in the top four bits
  assign run_ext = ProdBits'(run_value);
  assign prod    = (run_ext << 3) + (run_ext << 1) + ProdBits'(q_word.digit);
  assign sum_add = {1'b0, consumed_sum} + {1'b0, run_value};
  assign is_body = (q_word.op == OP_MATCH) || (q_word.op == OP_SKIP);

  always_comb begin
    case (phase)
      PH_LEAD_H: begin
        if (q_word.op == OP_HARD)      phase_next = PH_LEAD_H;
        else if (q_word.op == OP_SOFT) phase_next = PH_LEAD_S;
        else if (is_body)              phase_next = PH_BODY;
        else                           phase_next = PH_BAD;
      end
      PH_LEAD_S: begin
        if (q_word.op == OP_SOFT) phase_next = PH_LEAD_S;
        else if (is_body)         phase_next = PH_BODY;
        else                      phase_next = PH_BAD;
      end
      PH_BODY: begin
        if (is_body)                   phase_next = PH_BODY;
        else if (q_word.op == OP_SOFT) phase_next = PH_TRAIL_S;
        else if (q_word.op == OP_HARD) phase_next = PH_TRAIL_H;
        else                           phase_next = PH_BAD;
      end
      PH_TRAIL_S: begin
        if (q_word.op == OP_SOFT)      phase_next = PH_TRAIL_S;
        else if (q_word.op == OP_HARD) phase_next = PH_TRAIL_H;
        else                           phase_next = PH_BAD;
      end
      PH_TRAIL_H: begin
        if (q_word.op == OP_HARD) phase_next = PH_TRAIL_H;
        else                      phase_next = PH_BAD;
      end
      default: phase_next = PH_BAD;
    endcase
    if (q_word.op == OP_DIGIT || q_word.lone_star) begin
      phase_next = phase;
    end
  end

  always_comb begin
    run_value_next      = run_value;
    consumed_sum_next   = consumed_sum;
    saturated_flag_next = saturated_flag;
    if (q_word.op == OP_DIGIT) begin
      if (|prod[ProdBits-1:LengthBits]) begin
        run_value_next      = '1;
        saturated_flag_next = 1'b1;
      end else begin
        run_value_next = prod[LengthBits-1:0];
      end
    end else if (!q_word.lone_star) begin
      if (q_word.op == OP_MATCH || q_word.op == OP_SOFT) begin
        if (sum_add[LengthBits]) begin
          consumed_sum_next   = '1;
          saturated_flag_next = 1'b1;
        end else begin
          consumed_sum_next = sum_add[LengthBits-1:0];
        end
      end
      run_value_next = '0;
    end
  end

  assign sum_wide = WideBits'(consumed_sum_next);
  assign seq_wide = WideBits'(q_word.seq_length);
  assign match    = !saturated_flag_next && (sum_wide == seq_wide);
  assign order    = q_word.lone_star || (phase_next != PH_BAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEAD_H;
      run_value      <= '0;
      consumed_sum   <= '0;
      saturated_flag <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop && q_word.is_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (q_word.is_last) begin
          phase            <= PH_LEAD_H;
          run_value        <= '0;
          consumed_sum     <= '0;
          saturated_flag   <= 1'b0;
          cigar_valid      <= q_word.lone_star || (match && order);
          length_matches   <= match;
          order_legal      <= order;
          query_length_sum <= (sum_wide > WideBits'(32'hFFFF_FFFF)) ?
                              '1 : sum_wide[SEQ_BITS-1:0];
        end else begin
          phase          <= phase_next;
          run_value      <= run_value_next;
          consumed_sum   <= consumed_sum_next;
          saturated_flag <= saturated_flag_next;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/cigar_string_validator.sv =====
// ----------------------------------------------------------------------------
// cigar_string_validator
// Result words are registered in the back after the last word leaves the queue.
// Throughput: one character per cycle unless an untaken result stalls the back.
// A two-word queue separates character intake from the back update.
// Reset: synchronous rst clears the queue, per-string state and out_valid.
// ----------------------------------------------------------------------------
module cigar_string_validator #(
  parameter int LENGTH_BITS = csv_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   cigar_char,
  input  logic                         is_last,
  input  logic [csv_pkg::SEQ_BITS-1:0] seq_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         cigar_valid,
  output logic                         length_matches,
  output logic                         order_legal,
  output logic [csv_pkg::SEQ_BITS-1:0] query_length_sum
);
  import csv_pkg::*;

  logic      push;
  logic      wr_ready;
  csv_word_t wr_word;
  logic      q_valid;
  logic      q_ready;
  csv_word_t q_word;

  csv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cigar_char (cigar_char),
    .is_last    (is_last),
    .seq_length (seq_length),
    .q_ready    (wr_ready),
    .push       (push),
    .word       (wr_word)
  );

  csv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_word  (wr_word),
    .wr_ready (wr_ready),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_word  (q_word)
  );

  csv_back #(
    .LengthBits (LENGTH_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_word           (q_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cigar_valid      (cigar_valid),
    .length_matches   (length_matches),
    .order_legal      (order_legal),
    .query_length_sum (query_length_sum)
  );

`ifndef SYNTHESIS
  // a last word never pops while an untaken result still sits in the output
  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_word.is_last) |-> (!out_valid || out_ready))
    else $error("result overwritten");

  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_word.is_last) |=> out_valid)
    else $error("last word gave no result");

  assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (!q_word.lone_star || q_word.is_last))
    else $error("lone star on a non-last word");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

// ===== tb/sv/cigar_string_validator_tb.sv =====
// ----------------------------------------------------------------------------
// cigar_string_validator_tb
// Streams CIGAR strings one character per word and checks each verdict word
// against a cycle-free predictor of run accumulation, query-length summing
// with saturation and clip placement order. Directed strings cover lone star,
// clip order, unknown operations, trailing digits and saturation; random
// strings are mostly well formed with random runs, the rest noise. Both
// handshakes idle at random in the first two of three pressure phases.
// ----------------------------------------------------------------------------
module cigar_string_validator_tb;
  import csv_pkg::*;

  localparam int LEN_BITS = LENGTH_BITS_DEFAULT;
  localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_CHARS = 420;

  typedef enum logic [2:0] {
    CLIP_LEAD_H,
    CLIP_LEAD_S,
    CLIP_BODY,
    CLIP_TRAIL_S,
    CLIP_TRAIL_H,
    CLIP_REJECT
  } clip_phase_t;

  typedef struct {
    logic                verdict;
    logic                len_ok;
    logic                order_ok;
    logic [SEQ_BITS-1:0] qsum;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          cigar_char = 8'h00;
  logic                is_last = 1'b0;
  logic [SEQ_BITS-1:0] seq_length = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                cigar_valid;
  logic                length_matches;
  logic                order_legal;
  logic [SEQ_BITS-1:0] query_length_sum;

  clip_phase_t     phase_q;
  longint unsigned run_len;
  longint unsigned query_sum;
  bit              sat_seen;
  bit              first_char;
  verdict_t        verdict_q[$];
  int              errors = 0;
  int              cycle_count = 0;
  int              chars_sent = 0;
  int              send_idle_pct = 27;
  int              recv_idle_pct = 78;

  cigar_string_validator #(.LENGTH_BITS(LEN_BITS)) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cigar_char       (cigar_char),
    .is_last          (is_last),
    .seq_length       (seq_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cigar_valid      (cigar_valid),
    .length_matches   (length_matches),
    .order_legal      (order_legal),
    .query_length_sum (query_length_sum)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic bit is_body_op(logic [7:0] c);
    return c == CH_M || c == CH_I || c == CH_D || c == CH_N || c == CH_P ||
           c == CH_X || c == CH_EQ;
  endfunction

  function automatic bit consumes_query(logic [7:0] c);
    return c == CH_M || c == CH_I || c == CH_S || c == CH_EQ || c == CH_X;
  endfunction

  function automatic clip_phase_t next_clip(clip_phase_t ph, logic [7:0] c);
    bit h;
    bit s;
    bit b;
    h = (c == CH_H);
    s = (c == CH_S);
    b = is_body_op(c);
    case (ph)
      CLIP_LEAD_H: begin
        if (h) return CLIP_LEAD_H;
        if (s) return CLIP_LEAD_S;
        if (b) return CLIP_BODY;
      end
      CLIP_LEAD_S: begin
        if (s) return CLIP_LEAD_S;
        if (b) return CLIP_BODY;
      end
      CLIP_BODY: begin
        if (b) return CLIP_BODY;
        if (s) return CLIP_TRAIL_S;
        if (h) return CLIP_TRAIL_H;
      end
      CLIP_TRAIL_S: begin
        if (s) return CLIP_TRAIL_S;
        if (h) return CLIP_TRAIL_H;
      end
      CLIP_TRAIL_H: begin
        if (h) return CLIP_TRAIL_H;
      end
      default: ;
    endcase
    return CLIP_REJECT;
  endfunction

  function automatic void clear_string_state();
    phase_q = CLIP_LEAD_H;
    run_len = 0;
    query_sum = 0;
    sat_seen = 1'b0;
    first_char = 1'b1;
  endfunction

  function automatic void predict_char(logic [7:0] c, logic last,
                                       logic [SEQ_BITS-1:0] len);
    bit star_only;
    longint unsigned d;
    verdict_t v;
    star_only = first_char && last && (c == CH_STAR);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      if (run_len > (LEN_MAX - d) / 10) begin
        run_len = LEN_MAX;
        sat_seen = 1'b1;
      end else begin
        run_len = run_len * 10 + d;
      end
    end else if (!star_only) begin
      if (consumes_query(c)) begin
        if (query_sum > LEN_MAX - run_len) begin
          query_sum = LEN_MAX;
          sat_seen = 1'b1;
        end else begin
          query_sum = query_sum + run_len;
        end
      end
      phase_q = next_clip(phase_q, c);
      run_len = 0;
    end
    first_char = 1'b0;
    if (last) begin
      v.len_ok = !sat_seen && (query_sum == {32'd0, len});
      v.order_ok = star_only || (phase_q != CLIP_REJECT);
      v.verdict = star_only || (v.len_ok && v.order_ok);
      v.qsum = (query_sum > 64'hFFFF_FFFF) ? '1 : query_sum[SEQ_BITS-1:0];
      verdict_q.push_back(v);
      clear_string_state();
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned want,
                                 longint unsigned got);
    $display("ERROR cycle %0d %s: expected %0h got %0h", cycle_count, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result word", 0, 1);
      end else begin
        want = verdict_q.pop_front();
        if (cigar_valid !== want.verdict)
          report_mismatch("cigar_valid", want.verdict, cigar_valid);
        if (length_matches !== want.len_ok)
          report_mismatch("length_matches", want.len_ok, length_matches);
        if (order_legal !== want.order_ok)
          report_mismatch("order_legal", want.order_ok, order_legal);
        if (query_length_sum !== want.qsum)
          report_mismatch("query_length_sum", want.qsum, query_length_sum);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_char(logic [7:0] c, logic last, logic [SEQ_BITS-1:0] len);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cigar_char <= c;
    is_last <= last;
    seq_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(c, last, len);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_chars(logic [7:0] q[$], logic [SEQ_BITS-1:0] len, bit scramble);
    logic last;
    for (int i = 0; i < q.size(); i++) begin
      last = (i == q.size() - 1);
      send_char(q[i], last, (scramble && !last) ? $urandom : len);
    end
  endtask

  task automatic send_text(string s, logic [SEQ_BITS-1:0] len);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_chars(q, len, 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  function automatic longint unsigned random_run();
    case ($urandom_range(0, 39))
      0, 1: return 64'd0;
      2: return {$urandom, $urandom};
      3, 4: return 64'd4294967294 + $urandom_range(0, 2);
      5, 6, 7, 8, 9, 10: return $urandom_range(0, 99999);
      default: return $urandom_range(1, 150);
    endcase
  endfunction

  function automatic void append_digits(ref logic [7:0] q[$], input longint unsigned n);
    string t;
    t = $sformatf("%0d", n);
    if ($urandom_range(0, 15) == 0) q.push_back(CH_ZERO);
    for (int i = 0; i < t.len(); i++) q.push_back(t[i]);
  endfunction

  function automatic void add_op(ref logic [7:0] q[$], ref longint unsigned total,
                                 input logic [7:0] op);
    longint unsigned n;
    n = random_run();
    append_digits(q, n);
    q.push_back(op);
    if (consumes_query(op)) total = total + n;
  endfunction

  function automatic logic [7:0] pick_body_op();
    logic [7:0] ops[7];
    ops = '{CH_M, CH_I, CH_D, CH_N, CH_P, CH_X, CH_EQ};
    return ops[$urandom_range(0, 6)];
  endfunction

  function automatic void build_wellformed(ref logic [7:0] q[$],
                                           ref longint unsigned total);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_op(q, total, CH_H);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_op(q, total, CH_S);
    repeat ($urandom_range(1, 4)) add_op(q, total, pick_body_op());
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_op(q, total, CH_S);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_op(q, total, CH_H);
  endfunction

  function automatic void build_noise(ref logic [7:0] q[$], ref longint unsigned total);
    string glyphs;
    glyphs = "0123456789MIDNPSX=H*";
    case ($urandom_range(0, 7))
      0: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) q.push_back(8'($urandom_range(0, 255)));
          else q.push_back(glyphs[$urandom_range(0, glyphs.len() - 1)]);
        end
      end
      1: begin
        build_wellformed(q, total);
        repeat ($urandom_range(1, 3)) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      2: q.push_back(CH_STAR);
      3: append_digits(q, random_run());
      4: begin
        add_op(q, total, CH_S);
        add_op(q, total, CH_H);
        if ($urandom_range(0, 1)) add_op(q, total, pick_body_op());
      end
      5: begin
        build_wellformed(q, total);
        add_op(q, total, CH_H);
        add_op(q, total, $urandom_range(0, 1) ? CH_S : pick_body_op());
      end
      6: begin
        build_wellformed(q, total);
        q.push_back(CH_STAR);
      end
      default: begin
        q.push_back(pick_body_op());
        if ($urandom_range(0, 1)) add_op(q, total, pick_body_op());
      end
    endcase
  endfunction

  task automatic test_lone_star();
    send_text("*", 32'd0);
    send_text("*", 32'hFFFF_FFFF);
  endtask

  task automatic test_clip_order();
    send_text("1S2H", 32'd1);
    send_text("1M1H", 32'd1);
  endtask

  task automatic test_unknown_ops();
    send_text("1*", 32'd0);
    send_char(8'h00, 1'b1, 32'd0);
  endtask

  task automatic test_run_lengths();
    send_text("4M12", 32'd4);
    send_text("07", 32'd0);
    send_text("9999999999D", 32'd0);
  endtask

  task automatic test_random(int n_chars);
    logic [7:0] q[$];
    longint unsigned total;
    logic [SEQ_BITS-1:0] len;
    int stop_at;
    int strings;
    bit noisy;
    stop_at = chars_sent + n_chars;
    strings = 0;
    while (chars_sent < stop_at) begin
      q.delete();
      total = 0;
      noisy = ($urandom_range(0, 99) < 25);
      if (noisy) build_noise(q, total);
      else build_wellformed(q, total);
      case ($urandom_range(0, 9))
        0, 1: len = $urandom;
        2: len = total[SEQ_BITS-1:0] + 1'b1;
        3: len = total[SEQ_BITS-1:0] - 1'b1;
        default: len = total[SEQ_BITS-1:0];
      endcase
      send_chars(q, len, noisy && $urandom_range(0, 1));
      strings++;
      if (strings % 16 == 0) wait_drained();
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("cigar_string_validator: mismatch");
    $finish;
  end

  initial begin
    clear_string_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_lone_star();
    test_clip_order();
    test_unknown_ops();
    test_run_lengths();
    wait_drained();

    test_random(PHASE_CHARS);
    wait_drained();
    send_idle_pct = 78;
    recv_idle_pct = 27;
    test_random(PHASE_CHARS);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(PHASE_CHARS);
    wait_drained();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("cigar_string_validator: match");
    end else begin
      $display("cigar_string_validator: mismatch");
    end
    $finish;
  end

endmodule
